FILE: rtl/core/cidd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_pkg: shared types and constants of the compact id text decoder
// Holds the parse phase encoding, the character class bundle, the result
// bundle and the fixed numeric limits of the id format.
// ----------------------------------------------------------------------------
package cidd_pkg;

   // Largest decimal base; also the weight of one suffix step in the id.
   localparam logic [13:0] BASE_LIMIT = 14'd9999;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_LO  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_LO  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_HI  = 8'h7A;

   typedef enum logic [4:0] {
      PH_LEAD   = 5'b00001,
      PH_DIGITS = 5'b00010,
      PH_SUFFIX = 5'b00100,
      PH_TRAIL  = 5'b01000,
      PH_ERROR  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       is_end;
      logic       is_space;
      logic       is_digit;
      logic       is_letter;
      logic [3:0] digit;
      logic [4:0] letter;
   } char_class_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] id_value;
   } result_type;

   // Contribution of one suffix letter (1..26) to the id: letter * 9999.
   function automatic logic [17:0] letter_weight(input logic [4:0] letter);
      logic [17:0] weight;
      weight = 18'(letter) * 18'(BASE_LIMIT);
      return weight;
   endfunction

endpackage

FILE: rtl/core/cidd_char_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_char_class: byte classifier
// Sorts one text byte into end, whitespace, digit and letter classes and
// extracts the digit value and the bijective base-26 letter value.
// ----------------------------------------------------------------------------
module cidd_char_class (
   input  logic [7:0]              char_in,
   output cidd_pkg::char_class_type cls
);

   always_comb begin
      cls.is_end    = (char_in == cidd_pkg::CHAR_NUL);
      cls.is_space  = (char_in == cidd_pkg::CHAR_SPACE) ||
                      ((char_in >= cidd_pkg::CHAR_TAB) && (char_in <= cidd_pkg::CHAR_CR));
      cls.is_digit  = (char_in >= cidd_pkg::CHAR_DIGIT_LO) &&
                      (char_in <= cidd_pkg::CHAR_DIGIT_HI);
      cls.is_letter = ((char_in >= cidd_pkg::CHAR_UPPER_LO) &&
                       (char_in <= cidd_pkg::CHAR_UPPER_HI)) ||
                      ((char_in >= cidd_pkg::CHAR_LOWER_LO) &&
                       (char_in <= cidd_pkg::CHAR_LOWER_HI));
      // Digits sit at 0x30..0x39 and letters at 0x41/0x61 onward, so the low
      // bits already give the digit value and the letter value 1..26.
      cls.digit     = char_in[3:0];
      cls.letter    = char_in[4:0];
   end

endmodule

FILE: rtl/core/cidd_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidd_parse_core: parse state and id accumulation
// Holds the phase, the decimal base and the running suffix*9999 product,
// advances them by one classified byte per step and forms the result
// when the end byte arrives.
// ----------------------------------------------------------------------------
module cidd_parse_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  cidd_pkg::char_class_type cls,
   output cidd_pkg::result_type     result
);

   cidd_pkg::phase_type phase_ff, phase_in;
   logic [13:0]         base_ff, base_in;
   // Suffix is kept already scaled by 9999; over_ff marks that the scaled
   // value has left the 64-bit range, which dooms the id.
   logic [63:0]         prod_ff, prod_in;
   logic                over_ff, over_in;

   logic [17:0]         digit_sum;
   logic [68:0]         prod_sum;
   logic [64:0]         id_sum;
   logic                phase_has_id;

   always_comb begin
      digit_sum = ({4'd0, base_ff} << 3) + ({4'd0, base_ff} << 1) + {14'd0, cls.digit};
      prod_sum  = ({5'd0, prod_ff} << 4) + ({5'd0, prod_ff} << 3) + ({5'd0, prod_ff} << 1)
                  + {51'd0, cidd_pkg::letter_weight(cls.letter)};
   end

   always_comb begin
      phase_in = phase_ff;
      base_in  = base_ff;
      prod_in  = prod_ff;
      over_in  = over_ff;
      if (step_en) begin
         if (cls.is_end) begin
            phase_in = cidd_pkg::PH_LEAD;
            base_in  = 14'd0;
            prod_in  = 64'd0;
            over_in  = 1'b0;
         end else begin
            unique case (phase_ff)
               cidd_pkg::PH_LEAD: begin
                  if (cls.is_space) begin
                     phase_in = cidd_pkg::PH_LEAD;
                  end else if (cls.is_digit) begin
                     if (digit_sum > 18'(cidd_pkg::BASE_LIMIT)) begin
                        phase_in = cidd_pkg::PH_ERROR;
                     end else begin
                        base_in  = digit_sum[13:0];
                        phase_in = cidd_pkg::PH_DIGITS;
                     end
                  end else begin
                     phase_in = cidd_pkg::PH_ERROR;
                  end
               end
               cidd_pkg::PH_DIGITS: begin
                  if (cls.is_digit) begin
                     if (digit_sum > 18'(cidd_pkg::BASE_LIMIT)) begin
                        phase_in = cidd_pkg::PH_ERROR;
                     end else begin
                        base_in  = digit_sum[13:0];
                        phase_in = cidd_pkg::PH_DIGITS;
                     end
                  end else if (base_ff == 14'd0) begin
                     phase_in = cidd_pkg::PH_ERROR;
                  end else if (cls.is_space) begin
                     phase_in = cidd_pkg::PH_TRAIL;
                  end else if (cls.is_letter) begin
                     prod_in  = prod_sum[63:0];
                     over_in  = over_ff | (|prod_sum[68:64]);
                     phase_in = cidd_pkg::PH_SUFFIX;
                  end else begin
                     phase_in = cidd_pkg::PH_ERROR;
                  end
               end
               cidd_pkg::PH_SUFFIX: begin
                  if (cls.is_space) begin
                     phase_in = cidd_pkg::PH_TRAIL;
                  end else if (cls.is_letter) begin
                     prod_in  = prod_sum[63:0];
                     over_in  = over_ff | (|prod_sum[68:64]);
                     phase_in = cidd_pkg::PH_SUFFIX;
                  end else begin
                     phase_in = cidd_pkg::PH_ERROR;
                  end
               end
               cidd_pkg::PH_TRAIL: begin
                  if (!cls.is_space) begin
                     phase_in = cidd_pkg::PH_ERROR;
                  end
               end
               default: begin
                  phase_in = cidd_pkg::PH_ERROR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cidd_pkg::PH_LEAD;
         base_ff  <= 14'd0;
         prod_ff  <= 64'd0;
         over_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         prod_ff  <= prod_in;
         over_ff  <= over_in;
      end
   end

   always_comb begin
      phase_has_id = (phase_ff == cidd_pkg::PH_DIGITS) ||
                     (phase_ff == cidd_pkg::PH_SUFFIX) ||
                     (phase_ff == cidd_pkg::PH_TRAIL);
      id_sum          = {1'b0, prod_ff} + {51'd0, base_ff};
      result.ok       = phase_has_id && (base_ff != 14'd0) && !over_ff && !id_sum[64];
      result.id_value = result.ok ? id_sum[63:0] : 64'd0;
   end

endmodule

FILE: rtl/core/compact_id_text_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_id_text_decoder: streaming compact id text decoder
// Parses decimal base plus letter suffix text, one byte per transfer, and
// returns ok and id = suffix * 9999 + base when the terminating zero arrives.
// ----------------------------------------------------------------------------
//
//   channel   direction   ports                          carries
//   req       in          req_valid req_stall            req_char_in
//   rsp       out         rsp_valid rsp_stall            rsp_ok rsp_id_value
//
// One byte is taken every cycle while no zero byte waits in the input register.
// A byte is registered in the input register, then the parse step updates the
// state; a zero byte's result is loaded into the result register when it steps.
// Reset is synchronous and returns the parser to leading whitespace with
// empty accumulators and both registers empty.
// A zero byte waits in the input register while the result register holds an
// untaken result; any other byte in the input register steps regardless of rsp_stall.
// ----------------------------------------------------------------------------
module compact_id_text_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [63:0] rsp_id_value
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_char_ff;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_ok_ff;
   logic [63:0]              out_id_ff;
   logic                     advance;
   logic                     out_free;
   cidd_pkg::char_class_type cls;
   cidd_pkg::result_type     result;

   cidd_char_class u_class (
      .char_in (in_char_ff),
      .cls     (cls)
   );

   cidd_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cls     (cls),
      .result  (result)
   );

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && (!cls.is_end || out_free);
      req_stall    = in_valid_ff && !advance;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      if (advance && cls.is_end) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_in;
      end
      if (advance && cls.is_end) begin
         out_ok_ff <= result.ok;
         out_id_ff <= result.id_value;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_ok       = out_ok_ff;
   assign rsp_id_value = out_id_ff;

endmodule

FILE: tb/sv/compact_id_text_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_id_text_decoder_tb: self-checking bench for the compact id decoder
// Streams text bytes into the decoder and keeps its own parser to predict the
// ok flag and id for every zero byte. Covers the format limits, malformed
// text and both overflow checks, then runs random ids and noise. Random gaps
// and a long result hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module compact_id_text_decoder_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef logic [7:0] char_queue_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [63:0] rsp_id_value;

   // State of the bench's own parser.
   cidd_pkg::phase_type text_phase = cidd_pkg::PH_LEAD;
   logic [13:0]         base_sum = '0;
   logic [63:0]         suffix_sum = '0;

   cidd_pkg::result_type pending_ids[$];
   cidd_pkg::result_type oldest_id;
   int                   fail_count = 0;
   int                   cycle_count = 0;
   int                   sent_chars = 0;
   int                   hold_cycles = 0;
   bit                   gaps_on = 1'b1;

   compact_id_text_decoder uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ok       (rsp_ok),
      .rsp_id_value (rsp_id_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("compact_id_text_decoder verification failed");
         $finish;
      end
   end

   function automatic bit is_blank(input logic [7:0] c);
      return c == cidd_pkg::CHAR_SPACE ||
             (c >= cidd_pkg::CHAR_TAB && c <= cidd_pkg::CHAR_CR);
   endfunction

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= cidd_pkg::CHAR_DIGIT_LO && c <= cidd_pkg::CHAR_DIGIT_HI;
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= cidd_pkg::CHAR_LOWER_LO && c <= cidd_pkg::CHAR_LOWER_HI) ||
             (c >= cidd_pkg::CHAR_UPPER_LO && c <= cidd_pkg::CHAR_UPPER_HI);
   endfunction

   task automatic add_digit(input logic [7:0] c);
      logic [17:0] grown;
      grown = 18'(base_sum) * 18'd10 + 18'(c - cidd_pkg::CHAR_DIGIT_LO);
      if (grown > 18'(cidd_pkg::BASE_LIMIT)) begin
         text_phase = cidd_pkg::PH_ERROR;
      end else begin
         base_sum = grown[13:0];
         text_phase = cidd_pkg::PH_DIGITS;
      end
   endtask

   task automatic add_letter(input logic [7:0] c);
      logic [71:0] grown;
      logic [7:0]  value;
      value = (c >= cidd_pkg::CHAR_LOWER_LO) ? c - cidd_pkg::CHAR_LOWER_LO + 8'd1
                                              : c - cidd_pkg::CHAR_UPPER_LO + 8'd1;
      grown = {8'h00, suffix_sum} * 72'd26 + 72'(value);
      if (grown > 72'(64'hFFFF_FFFF_FFFF_FFFF)) begin
         text_phase = cidd_pkg::PH_ERROR;
      end else begin
         suffix_sum = grown[63:0];
         text_phase = cidd_pkg::PH_SUFFIX;
      end
   endtask

   // Advances the parser by one byte; a zero byte yields a result.
   task automatic decode_char(input logic [7:0] c, output bit done,
                              output cidd_pkg::result_type res);
      logic [79:0] full_id;
      done = 1'b0;
      res = '0;
      if (c == cidd_pkg::CHAR_NUL) begin
         done = 1'b1;
         full_id = {16'h0000, suffix_sum} * 80'(cidd_pkg::BASE_LIMIT) + 80'(base_sum);
         if ((text_phase == cidd_pkg::PH_DIGITS || text_phase == cidd_pkg::PH_SUFFIX ||
              text_phase == cidd_pkg::PH_TRAIL)
             && base_sum != 0 && full_id <= 80'(64'hFFFF_FFFF_FFFF_FFFF)) begin
            res.ok = 1'b1;
            res.id_value = full_id[63:0];
         end
         text_phase = cidd_pkg::PH_LEAD;
         base_sum = '0;
         suffix_sum = '0;
      end else begin
         case (text_phase)
            cidd_pkg::PH_LEAD: begin
               if (is_numeral(c)) add_digit(c);
               else if (!is_blank(c)) text_phase = cidd_pkg::PH_ERROR;
            end
            cidd_pkg::PH_DIGITS: begin
               if (is_numeral(c)) add_digit(c);
               else if (base_sum == 0) text_phase = cidd_pkg::PH_ERROR;
               else if (is_blank(c)) text_phase = cidd_pkg::PH_TRAIL;
               else if (is_alpha(c)) add_letter(c);
               else text_phase = cidd_pkg::PH_ERROR;
            end
            cidd_pkg::PH_SUFFIX: begin
               if (is_blank(c)) text_phase = cidd_pkg::PH_TRAIL;
               else if (is_alpha(c)) add_letter(c);
               else text_phase = cidd_pkg::PH_ERROR;
            end
            cidd_pkg::PH_TRAIL: begin
               if (!is_blank(c)) text_phase = cidd_pkg::PH_ERROR;
            end
            default: text_phase = cidd_pkg::PH_ERROR;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      fail_count++;
      $display("MISMATCH at cycle %0d: %s: expected %0d, got %0d",
               cycle_count, what, want, got);
   endtask

   // Offers one byte and records the predicted result once it is accepted.
   task automatic send_char(input logic [7:0] c);
      bit                   done;
      cidd_pkg::result_type res;
      while (gaps_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_char(c, done, res);
      if (done) pending_ids.push_back(res);
      sent_chars++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_char(cidd_pkg::CHAR_NUL);
   endtask

   function automatic logic [7:0] random_blank();
      int pick;
      pick = $urandom_range(5);
      return (pick == 5) ? cidd_pkg::CHAR_SPACE : cidd_pkg::CHAR_TAB + 8'(pick);
   endfunction

   // Id-shaped random text, without the terminating zero; it may break the limits.
   function automatic char_queue_type random_id_text();
      char_queue_type t;
      int             n_digits;
      int             n_letters;
      int             pick;
      t = {};
      repeat ($urandom_range(2)) t.push_back(random_blank());
      n_digits = ($urandom_range(9) == 0) ? 5 : $urandom_range(1, 4);
      repeat (n_digits) t.push_back(cidd_pkg::CHAR_DIGIT_LO + 8'($urandom_range(9)));
      pick = $urandom_range(99);
      n_letters = (pick < 30) ? 0 : (pick < 88) ? $urandom_range(1, 4) : $urandom_range(5, 14);
      repeat (n_letters)
         t.push_back(($urandom_range(1) ? cidd_pkg::CHAR_LOWER_LO : cidd_pkg::CHAR_UPPER_LO) +
                     8'($urandom_range(25)));
      repeat ($urandom_range(2)) t.push_back(random_blank());
      return t;
   endfunction

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(99) < 17);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ids.size() == 0) begin
            report_mismatch("result with nothing pending", 64'd0, rsp_id_value);
         end else begin
            oldest_id = pending_ids.pop_front();
            if (rsp_ok !== oldest_id.ok)
               report_mismatch("ok flag", 64'(oldest_id.ok), 64'(rsp_ok));
            if (rsp_id_value !== oldest_id.id_value)
               report_mismatch("id value", oldest_id.id_value, rsp_id_value);
         end
      end
   end

   task automatic test_valid_forms();
      send_line("1");
      send_line("9999");
      send_line("0007");
      for (logic [7:0] c = cidd_pkg::CHAR_TAB; c <= cidd_pkg::CHAR_CR; c++) send_char(c);
      send_char(cidd_pkg::CHAR_SPACE);
      send_line("42 ");
      send_line("12a");
      send_line("34Z");
      send_line("5aZ \t");
   endtask

   task automatic test_malformed_text();
      send_line("10000");
      send_line("0");
      send_line("0a");
      send_line("0 ");
      send_char(cidd_pkg::CHAR_NUL);
      send_line("  ");
      send_line("a1");
      send_line("12 a");
      send_line("1a1");
      send_line("12@");
      send_text("12");
      send_char(8'h80);
      send_char(cidd_pkg::CHAR_NUL);
      send_char(8'hFF);
      send_char(cidd_pkg::CHAR_NUL);
   endtask

   task automatic test_overflow_limits();
      // Ten letters still fit the id, eleven overflow it, fourteen overflow the suffix.
      send_line("9999zzzzzzzzzz");
      send_line("1zzzzzzzzzzz");
      send_line("1zzzzzzzzzzzzzz5");
   endtask

   task automatic test_result_backpressure();
      // The last byte is already taken, so nothing is offered while waiting.
      req_valid <= 1'b0;
      @(posedge clock);
      hold_cycles = 300;
      @(negedge clock);
      repeat (20) send_line($sformatf("%0d", $urandom_range(1, 9999)));
   endtask

   task automatic test_random_ids(input int char_budget);
      char_queue_type t;
      int             stop_at;
      stop_at = sent_chars + char_budget;
      while (sent_chars < stop_at) begin
         t = random_id_text();
         // An occasional corrupted byte can send the parser down its error path.
         if ($urandom_range(9) == 0) t[$urandom_range(t.size() - 1)] = 8'($urandom_range(1, 255));
         foreach (t[i]) send_char(t[i]);
         send_char(cidd_pkg::CHAR_NUL);
      end
   endtask

   task automatic test_steady_stream();
      gaps_on = 1'b0;
      test_random_ids(250);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_noise(input int char_budget);
      int stop_at;
      stop_at = sent_chars + char_budget;
      while (sent_chars < stop_at)
         send_char(($urandom_range(7) == 0) ? cidd_pkg::CHAR_NUL : 8'($urandom_range(255)));
      send_char(cidd_pkg::CHAR_NUL);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_valid_forms();
      test_malformed_text();
      test_overflow_limits();
      test_result_backpressure();
      test_random_ids(950);
      test_steady_stream();
      test_random_noise(200);
      req_valid <= 1'b0;
      while (pending_ids.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("compact_id_text_decoder verification clean");
      end else begin
         $display("compact_id_text_decoder verification failed");
      end
      $finish;
   end

endmodule
